[hw/rtl/mca_pkg.sv]
// ----------------------------------------------------------------------------
// MOSI coherence agent package
// Shared state, message and action codes, and the MOSI transition function.
// ----------------------------------------------------------------------------
package mca_pkg;

  localparam int LineW  = 10;
  localparam int BlockW = 48;

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_M  = 3'd2,
    ST_O  = 3'd3,
    ST_IS = 3'd4,
    ST_IM = 3'd5,
    ST_SM = 3'd6,
    ST_OM = 3'd7
  } coh_state_e;

  typedef enum logic [2:0] {
    K_LOAD    = 3'd0,
    K_STORE   = 3'd1,
    K_REQINV  = 3'd2,
    K_RECALLI = 3'd3,
    K_RECALLS = 3'd4,
    K_DATA    = 3'd5,
    K_ACK     = 3'd6,
    K_OTHER   = 3'd7
  } msg_kind_e;

  typedef enum logic [2:0] {
    A_NONE   = 3'd0,
    A_GETS   = 3'd1,
    A_GETM   = 3'd2,
    A_DPROC  = 3'd3,
    A_DDIR   = 3'd4,
    A_INVACK = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    E_OK    = 2'd0,
    E_PROC  = 2'd1,
    E_NTWK  = 2'd2,
    E_TRANS = 2'd3
  } err_e;

  localparam logic SIDE_PROC = 1'b0;

  typedef enum logic [1:0] {
    CTRL_CLEAR  = 2'd0,
    CTRL_IDLE   = 2'd1,
    CTRL_LOOKUP = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    action_e    action;
    logic       miss;
    err_e       error;
    coh_state_e next_state;
  } xlate_t;

  function automatic xlate_t mca_transition(input logic side, input coh_state_e cur,
                                            input msg_kind_e kind);
    xlate_t r;
    r.action     = A_NONE;
    r.miss       = 1'b0;
    r.error      = E_OK;
    r.next_state = cur;
    if (side == SIDE_PROC) begin
      case (cur)
        ST_I: begin
          if (kind == K_LOAD) begin
            r.action = A_GETS; r.next_state = ST_IS; r.miss = 1'b1;
          end else if (kind == K_STORE) begin
            r.action = A_GETM; r.next_state = ST_IM; r.miss = 1'b1;
          end else begin
            r.error = E_PROC;
          end
        end
        ST_S: begin
          if (kind == K_LOAD) begin
            r.action = A_DPROC;
          end else if (kind == K_STORE) begin
            r.action = A_GETM; r.next_state = ST_SM;
          end else begin
            r.error = E_PROC;
          end
        end
        ST_M: begin
          if (kind == K_LOAD || kind == K_STORE) r.action = A_DPROC;
          else r.error = E_PROC;
        end
        ST_O: begin
          if (kind == K_LOAD) begin
            r.action = A_DPROC;
          end else if (kind == K_STORE) begin
            r.action = A_GETM; r.next_state = ST_OM;
          end else begin
            r.error = E_PROC;
          end
        end
        default: r.error = E_TRANS;
      endcase
    end else begin
      r.error = E_NTWK;
      case (cur)
        ST_S: begin
          if (kind == K_REQINV) begin
            r.action = A_INVACK; r.next_state = ST_I; r.error = E_OK;
          end
        end
        ST_M, ST_O: begin
          if (kind == K_RECALLI) begin
            r.action = A_DDIR; r.next_state = ST_I; r.error = E_OK;
          end else if (kind == K_RECALLS) begin
            r.action = A_DDIR; r.next_state = ST_O; r.error = E_OK;
          end
        end
        ST_IS: begin
          if (kind == K_DATA) begin
            r.action = A_DPROC; r.next_state = ST_S; r.error = E_OK;
          end
        end
        ST_IM: begin
          if (kind == K_DATA) begin
            r.action = A_DPROC; r.next_state = ST_M; r.error = E_OK;
          end
        end
        ST_SM: begin
          if (kind == K_REQINV) begin
            r.action = A_INVACK; r.next_state = ST_IM; r.error = E_OK;
          end else if (kind == K_ACK) begin
            r.action = A_DPROC; r.next_state = ST_M; r.error = E_OK;
          end
        end
        ST_OM: begin
          if (kind == K_RECALLS) begin
            r.action = A_DDIR; r.error = E_OK;
          end else if (kind == K_RECALLI) begin
            r.action = A_DDIR; r.next_state = ST_IM; r.error = E_OK;
          end else if (kind == K_ACK) begin
            r.action = A_DPROC; r.next_state = ST_M; r.error = E_OK;
          end
        end
        default: r.error = E_NTWK;
      endcase
    end
    // Unexpected message: keep the line state, send nothing.
    if (r.error != E_OK) begin
      r.action     = A_NONE;
      r.miss       = 1'b0;
      r.next_state = cur;
    end
    return r;
  endfunction

endpackage

[hw/rtl/mca_if.sv]
// ----------------------------------------------------------------------------
// MOSI coherence agent channels
// Valid/ready channels for incoming messages and outgoing results.
// ----------------------------------------------------------------------------
interface mca_in_if;
  import mca_pkg::*;
  logic              valid;
  logic              ready;
  logic              side;
  logic [2:0]        kind;
  logic [LineW-1:0]  line;
  logic [BlockW-1:0] block;

  modport source (output valid, side, kind, line, block, input ready);
  modport sink   (input valid, side, kind, line, block, output ready);
endinterface

interface mca_out_if;
  import mca_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [BlockW-1:0] out_block;
  logic              miss;
  logic [1:0]        error;
  logic [2:0]        next_state;

  modport source (output valid, action, out_block, miss, error, next_state, input ready);
  modport sink   (input valid, action, out_block, miss, error, next_state, output ready);
endinterface

[hw/rtl/mca_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mca_ram #(
  parameter  int Width = 3,
  parameter  int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mosi_coherence_agent.sv]
// ----------------------------------------------------------------------------
// MOSI coherence agent
// Per-line coherence state in a RAM; one message is looked up, translated and
// written back at a time.
// ----------------------------------------------------------------------------
// After reset the agent sweeps the state RAM to I, one line per cycle, over all
// NUM_LINES lines; no transaction is accepted during that pass. For each message
// the line state is read from the RAM when it is accepted; in the lookup state the
// MOSI table is applied, the new state written back and the result register loaded.
// The next message is accepted only once that lookup completes. A new message is
// accepted while an earlier result still waits in the output register; the lookup
// holds only if that register is still full when the next result is due.
// Line indices at or above NUM_LINES read as I and are never written.
module mosi_coherence_agent
  import mca_pkg::*;
#(
  parameter int NUM_LINES = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mca_in_if.sink    in_i,
  mca_out_if.source out_o
);

  localparam int AddrW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int ExtW  = 17;

  ctrl_state_e state_q, state_d;

  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0]  addr_q;
  logic              in_range_q;
  logic              side_q;
  msg_kind_e         kind_q;
  logic [BlockW-1:0] block_q;

  logic              out_valid_q, out_valid_d;
  xlate_t            res_q;
  logic [BlockW-1:0] out_block_q;

  logic [ExtW-1:0]   line_ext;
  logic [AddrW-1:0]  in_addr;
  logic              in_range;
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              clr_last;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [2:0]        ram_wdata;
  logic [2:0]        ram_rdata;
  coh_state_e        cur_state;
  xlate_t            res;

  assign line_ext = ExtW'(in_i.line);
  assign in_addr  = line_ext[AddrW-1:0];
  assign in_range = line_ext < ExtW'(NUM_LINES);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign clr_last = clr_cnt_q == AddrW'(NUM_LINES - 1);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTRL_CLEAR:  if (clr_last) state_d = CTRL_IDLE;
      CTRL_IDLE:   if (accept) state_d = CTRL_LOOKUP;
      CTRL_LOOKUP: if (out_free) state_d = CTRL_IDLE;
      default:     state_d = CTRL_CLEAR;
    endcase
  end

  // Output logic
  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = res.next_state;
    clr_cnt_d  = clr_cnt_q;
    case (state_q)
      CTRL_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = ST_I;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
      CTRL_IDLE: in_i.ready = 1'b1;
      CTRL_LOOKUP: begin
        load_out = out_free;
        ram_we   = out_free && in_range_q;
      end
      default: ;
    endcase
  end

  assign cur_state = in_range_q ? coh_state_e'(ram_rdata) : ST_I;
  assign res       = mca_transition(side_q, cur_state, kind_q);

  mca_ram #(
    .Width (3),
    .Depth (NUM_LINES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the transaction and the finished result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= in_addr;
      in_range_q <= in_range;
      side_q     <= in_i.side;
      kind_q     <= msg_kind_e'(in_i.kind);
      block_q    <= in_i.block;
    end
    if (load_out) begin
      res_q       <= res;
      out_block_q <= (res.action != A_NONE) ? block_q : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.action     = res_q.action;
  assign out_o.out_block  = out_block_q;
  assign out_o.miss       = res_q.miss;
  assign out_o.error      = res_q.error;
  assign out_o.next_state = res_q.next_state;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTRL_CLEAR |-> !in_i.ready)
    else $error("transaction accepted during state clear");

  a_lookup_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == CTRL_LOOKUP)
    else $error("accepted transaction did not reach lookup");

  a_writeback_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != CTRL_CLEAR) |-> load_out)
    else $error("state written back without a result");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.error != E_OK) |-> (res_q.action == A_NONE && !res_q.miss))
    else $error("error result sends a message or flags a miss");

  a_miss_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.miss) |->
      (res_q.next_state == ST_IS || res_q.next_state == ST_IM))
    else $error("miss without move to IS or IM");
`endif

endmodule

[tb/sv/tb_mosi_coherence_agent.sv]
// ----------------------------------------------------------------------------
// MOSI coherence agent testbench
// Drives processor requests and network messages into the agent and checks
// every result against a per-line coherence state mirror kept in the bench.
// A directed table walks each stable and transient state through its legal
// and illegal messages, then random traffic on a few busy lines follows
// mostly legal transitions, under random idling on both channels and one
// long output stall.
// ----------------------------------------------------------------------------
module tb_mosi_coherence_agent;
  import mca_pkg::*;

  localparam int   NumLines    = 1024;
  localparam int   StallCycles = 64;
  localparam logic SideNtwk    = 1'b1;
  localparam logic Typed       = 1'b1;
  localparam logic Predicted   = 1'b0;

  typedef struct packed {
    action_e           action;
    logic [BlockW-1:0] out_block;
    logic              miss;
    err_e              error;
    coh_state_e        next_state;
  } coh_result_t;

  typedef struct packed {
    logic              side;
    msg_kind_e         kind;
    logic [LineW-1:0]  line;
    logic [BlockW-1:0] block;
    logic              typed;
    action_e           act;
    logic              miss;
    err_e              err;
    coh_state_e        nxt;
  } dir_row_t;

  localparam int NumDir = 28;

  // Expected values are given only for misses from I and for error codes.
  localparam dir_row_t DirPlan [NumDir] = '{
    '{SIDE_PROC, K_LOAD,    10'd0,    48'hFFFF_FFFF_FFFF, Typed, A_GETS, 1'b1, E_OK,    ST_IS},
    '{SIDE_PROC, K_LOAD,    10'd0,    48'h8000_0000_0001, Typed, A_NONE, 1'b0, E_TRANS, ST_IS},
    '{SideNtwk,  K_ACK,     10'd0,    48'h1234_5678_9ABC, Typed, A_NONE, 1'b0, E_NTWK,  ST_IS},
    '{SideNtwk,  K_DATA,    10'd0,    48'hAAAA_AAAA_AAAA, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_LOAD,    10'd0,    48'h5555_5555_5555, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_OTHER,   10'd0,    48'hFFFF_FFFF_FFFF, Typed, A_NONE, 1'b0, E_PROC,  ST_S},
    '{SIDE_PROC, K_STORE,   10'd0,    48'h0000_0000_0001, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_ACK,     10'd0,    48'h8000_0000_0000, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_STORE,   10'd0,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_RECALLS, 10'd0,    48'h0F0F_0F0F_0F0F, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_LOAD,    10'd0,    48'hF0F0_F0F0_F0F0, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_STORE,   10'd0,    48'h0000_0000_0000, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_STORE,   10'd0,    48'hFFFF_FFFF_FFFF, Typed, A_NONE, 1'b0, E_TRANS, ST_OM},
    '{SideNtwk,  K_RECALLS, 10'd0,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_ACK,     10'd0,    48'h0000_FFFF_0000, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_RECALLS, 10'd0,    48'hFFFF_0000_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_RECALLI, 10'd0,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_REQINV,  10'd1023, 48'hFFFF_FFFF_FFFF, Typed, A_NONE, 1'b0, E_NTWK,  ST_I},
    '{SIDE_PROC, K_STORE,   10'd1023, 48'h0000_0000_0000, Typed, A_GETM, 1'b1, E_OK,    ST_IM},
    '{SideNtwk,  K_DATA,    10'd1023, 48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_OTHER,   10'd1023, 48'hFFFF_FFFF_FFFF, Typed, A_NONE, 1'b0, E_NTWK,  ST_M},
    '{SIDE_PROC, K_LOAD,    10'd1,    48'h0000_0000_0000, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_DATA,    10'd1,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_REQINV,  10'd1,    48'hAAAA_5555_AAAA, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_LOAD,    10'd2,    48'h5555_AAAA_5555, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_DATA,    10'd2,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SIDE_PROC, K_STORE,   10'd2,    48'h0000_0000_0000, Predicted, A_NONE, 1'b0, E_OK, ST_I},
    '{SideNtwk,  K_REQINV,  10'd2,    48'hFFFF_FFFF_FFFF, Predicted, A_NONE, 1'b0, E_OK, ST_I}
  };

  localparam logic [LineW-1:0] HotLines [8] = '{
    10'd0, 10'd1, 10'd2, 10'd3, 10'd341, 10'd512, 10'd682, 10'd1023
  };

  logic clk;
  logic rst_n;

  mca_in_if  in_if ();
  mca_out_if out_if ();

  mosi_coherence_agent #(
    .NUM_LINES(NumLines)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  coh_state_e  coh_mirror [NumLines];
  coh_result_t result_q [$];
  int          mismatches;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          stall_asked;
  int          stall_taken;
  int          hold_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one message to the state mirror and return the result it causes.
  function automatic coh_result_t apply_coherence(input logic sd, input msg_kind_e kd,
                                                  input logic [LineW-1:0] ln,
                                                  input logic [BlockW-1:0] blk);
    coh_result_t r;
    coh_state_e  cur;
    bit          in_range;
    in_range = (int'(ln) < NumLines);
    cur = in_range ? coh_mirror[ln] : ST_I;
    r.action     = A_NONE;
    r.error      = E_OK;
    r.next_state = cur;
    if (sd == SIDE_PROC) begin
      case (cur)
        ST_IS, ST_IM, ST_SM, ST_OM: r.error = E_TRANS;
        default: begin
          if (kd == K_LOAD) begin
            r.action     = (cur == ST_I) ? A_GETS : A_DPROC;
            r.next_state = (cur == ST_I) ? ST_IS : cur;
          end else if (kd == K_STORE) begin
            case (cur)
              ST_I:    begin r.action = A_GETM;  r.next_state = ST_IM; end
              ST_S:    begin r.action = A_GETM;  r.next_state = ST_SM; end
              ST_O:    begin r.action = A_GETM;  r.next_state = ST_OM; end
              default: r.action = A_DPROC;
            endcase
          end else begin
            r.error = E_PROC;
          end
        end
      endcase
    end else begin
      case ({cur, kd})
        {ST_S, K_REQINV}:                     begin r.action = A_INVACK; r.next_state = ST_I;  end
        {ST_M, K_RECALLI}, {ST_O, K_RECALLI}: begin r.action = A_DDIR;   r.next_state = ST_I;  end
        {ST_M, K_RECALLS}, {ST_O, K_RECALLS}: begin r.action = A_DDIR;   r.next_state = ST_O;  end
        {ST_IS, K_DATA}:                      begin r.action = A_DPROC;  r.next_state = ST_S;  end
        {ST_IM, K_DATA}:                      begin r.action = A_DPROC;  r.next_state = ST_M;  end
        {ST_SM, K_REQINV}:                    begin r.action = A_INVACK; r.next_state = ST_IM; end
        {ST_SM, K_ACK}, {ST_OM, K_ACK}:       begin r.action = A_DPROC;  r.next_state = ST_M;  end
        {ST_OM, K_RECALLS}:                   begin r.action = A_DDIR;   r.next_state = ST_OM; end
        {ST_OM, K_RECALLI}:                   begin r.action = A_DDIR;   r.next_state = ST_IM; end
        default:                              r.error = E_NTWK;
      endcase
    end
    r.miss      = (sd == SIDE_PROC) && (cur == ST_I) && (r.error == E_OK);
    r.out_block = (r.action != A_NONE) ? blk : '0;
    if (in_range) coh_mirror[ln] = r.next_state;
    return r;
  endfunction

  // Pick a message that the line's current state accepts.
  function automatic void pick_legal(input coh_state_e cur, output logic sd,
                                     output msg_kind_e kd);
    int pick;
    pick = $urandom_range(0, 3);
    sd = SideNtwk;
    case (cur)
      ST_I: begin
        sd = SIDE_PROC;
        kd = pick[0] ? K_STORE : K_LOAD;
      end
      ST_S: begin
        case (pick)
          0:       begin sd = SIDE_PROC; kd = K_LOAD;  end
          1:       begin sd = SIDE_PROC; kd = K_STORE; end
          default: kd = K_REQINV;
        endcase
      end
      ST_M, ST_O: begin
        case (pick)
          0:       begin sd = SIDE_PROC; kd = K_LOAD;  end
          1:       begin sd = SIDE_PROC; kd = K_STORE; end
          2:       kd = K_RECALLS;
          default: kd = K_RECALLI;
        endcase
      end
      ST_IS, ST_IM: kd = K_DATA;
      ST_SM:        kd = pick[0] ? K_ACK : K_REQINV;
      default: begin
        case (pick)
          0:       kd = K_RECALLS;
          1:       kd = K_RECALLI;
          default: kd = K_ACK;
        endcase
      end
    endcase
  endfunction

  // Offer one message; valid stays high across back-to-back transactions.
  task automatic send_msg(input logic sd, input msg_kind_e kd, input logic [LineW-1:0] ln,
                          input logic [BlockW-1:0] blk, input logic typed,
                          input coh_result_t typed_res);
    coh_result_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.side  <= sd;
    in_if.kind  <= kd;
    in_if.line  <= ln;
    in_if.block <= blk;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    res = apply_coherence(sd, kd, ln, blk);
    if (typed) res = typed_res;
    result_q.push_back(res);
  endtask

  task automatic send_random(input int count);
    logic [LineW-1:0]  ln;
    logic [BlockW-1:0] blk;
    logic              sd;
    msg_kind_e         kd;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) ln = HotLines[$urandom_range(0, 7)];
      else ln = LineW'($urandom_range(0, NumLines - 1));
      blk = BlockW'({$urandom(), $urandom()});
      // Mostly legal transitions, some noise to hit the error paths.
      if ($urandom_range(0, 99) < 15) begin
        sd = 1'($urandom_range(0, 1));
        kd = msg_kind_e'($urandom_range(0, 7));
      end else begin
        pick_legal(coh_mirror[ln], sd, kd);
      end
      send_msg(sd, kd, ln, blk, Predicted, '0);
    end
  endtask

  // Result channel: random back-pressure plus one long hold on request.
  always @(posedge clk) begin
    if (stall_asked != stall_taken) begin
      stall_taken = stall_asked;
      hold_left   = StallCycles;
    end
    if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    coh_result_t res;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: action %0d state %0d",
                                       out_if.action, out_if.next_state);
      end else begin
        res = result_q.pop_front();
        if (out_if.action !== res.action || out_if.out_block !== res.out_block ||
            out_if.miss !== res.miss || out_if.error !== res.error ||
            out_if.next_state !== res.next_state) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: action %0d block %h miss %0d error %0d state %0d",
                     res.action, res.out_block, res.miss, res.error, res.next_state);
            $display("         got: action %0d block %h miss %0d error %0d state %0d",
                     out_if.action, out_if.out_block, out_if.miss, out_if.error,
                     out_if.next_state);
          end
        end
      end
    end
  end

  initial begin
    coh_result_t typed_res;
    dir_row_t    row;
    in_if.valid   = 1'b0;
    in_if.side    = SIDE_PROC;
    in_if.kind    = K_LOAD;
    in_if.line    = '0;
    in_if.block   = '0;
    out_if.ready  = 1'b0;
    mismatches    = 0;
    stall_asked   = 0;
    stall_taken   = 0;
    hold_left     = 0;
    src_idle_pct  = 38;
    sink_idle_pct = 50;
    for (int i = 0; i < NumLines; i++) coh_mirror[i] = ST_I;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      row = DirPlan[i];
      typed_res.action     = row.act;
      typed_res.out_block  = (row.act != A_NONE) ? row.block : '0;
      typed_res.miss       = row.miss;
      typed_res.error      = row.err;
      typed_res.next_state = row.nxt;
      send_msg(row.side, row.kind, row.line, row.block, row.typed, typed_res);
    end
    send_random(180);

    src_idle_pct  = 50;
    sink_idle_pct = 38;
    send_random(180);

    // Hold the result channel while the sender streams, to fill the agent.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_asked   = stall_asked + 1;
    send_random(190);
    in_if.valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Covers the clearing pass after reset and every stall with wide margin.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
